>>> sv/gtp_pkg.sv
// Package for the Goertzel tone power block: widths, register map, FSM and term codes.
`default_nettype none

package gtp_pkg;

   // Default parameter values
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF    = 48;

   // Fixed field widths
   localparam int COEF_WIDTH     = 16;
   localparam int WLEN_WIDTH     = 16;
   localparam int POWER_WIDTH    = 63;
   localparam int MAG_WIDTH      = 32;
   localparam int RSP_DATA_WIDTH = 96;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Shared multiplier digit width and fixed-point shifts
   localparam int DIGIT_WIDTH  = 16;
   localparam int COEF_FRAC    = 14;
   localparam int POWER_SHIFT  = 16;

   // Square root unit: 64-bit radicand, two bits per step
   localparam int          ROOT_WIDTH    = 64;
   localparam int          ROOT_STEPS    = 32;
   localparam int          ROOT_CNT_W    = 5;
   localparam logic [63:0] ROOT_BIT_INIT = 64'h4000_0000_0000_0000;

   // Register index (address bit 2)
   typedef enum logic {
      REG_COEFFICIENT   = 1'b0,
      REG_WINDOW_LENGTH = 1'b1
   } csr_reg_type;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_MAC    = 9'b0_0000_0010,
      ST_UPDATE = 9'b0_0000_0100,
      ST_LOAD   = 9'b0_0000_1000,
      ST_ACCUM  = 9'b0_0001_0000,
      ST_POWER  = 9'b0_0010_0000,
      ST_ROOT   = 9'b0_0100_0000,
      ST_EMIT   = 9'b0_1000_0000,
      ST_SPARE  = 9'b1_0000_0000
   } state_type;

   // Which product the shared multiplier is working on
   typedef enum logic [2:0] {
      TERM_SAMPLE = 3'd0,
      TERM_SQ1    = 3'd1,
      TERM_SQ2    = 3'd2,
      TERM_CQ     = 3'd3,
      TERM_CROSS  = 3'd4
   } term_type;

endpackage

`default_nettype wire

>>> sv/goertzel_tone_power.sv
// Single-bin Goertzel tone power detector with a shared iterative multiplier.
//
// Usage: samples arrive on the req_ stream (one signed sample per transaction).
// Each sample runs the Goertzel recurrence on two saturating accumulators. After
// window_length samples, one result transaction leaves on the rsp_ stream with
// the bin power (shifted right 16, clamped, saturated to 63 bits), its floor
// square root and an overflow flag; the accumulators then clear.
// A sample passes through accept, one multiplier digit step and update;
// req_tready is high only in the idle state, so a sample is not taken until
// the last one is through. The sample that closes a window adds the power
// pass: 4 multiplier passes (d1^2, d2^2, c*d1 and the cross product, each
// loaded then accumulated), a clamp and 32 square root steps. req_tready
// returns when the result is loaded into the output register.
// The result sits in an output register; the block takes new samples while it
// waits. If a second result is ready before the first is taken, the block holds
// in its emit state until rsp_tready.
// Reset (synchronous, active high) clears the accumulators, count and flag,
// sets coefficient to 0 and window_length to 1024, and drops rsp_tvalid.
// Configuration (APB, pready always high): coefficient at 0x0, window_length at 0x4.
`default_nettype none

module goertzel_tone_power import gtp_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Sample stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,   // [SW-1:0] sample
   // Result stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]                 rsp_tdata,   // [62:0] power, [94:63] magnitude, [95] zero
   output logic                                      rsp_tuser,   // [0] overflow
   // Configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]            csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]            csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]                 csr_prdata,
   output logic                                      csr_pready
);

   localparam int ND       = (ACC_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int NDQ      = (ACC_WIDTH + 2*DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int MW       = DIGIT_WIDTH * NDQ;
   localparam int TW       = ACC_WIDTH + MW;
   localparam int AW       = 2*ACC_WIDTH + 16;
   localparam int AWE      = (AW > 96) ? AW : 96;
   localparam int PW       = ACC_WIDTH + DIGIT_WIDTH + 1;
   localparam int NW       = ACC_WIDTH + DIGIT_WIDTH + 2;
   localparam int CW       = $clog2(NDQ + 1);
   localparam int SQ_SHIFT = MW - DIGIT_WIDTH*ND;
   localparam int C_SHIFT  = MW - DIGIT_WIDTH;

   // Control state
   state_type                     state_ff, state_in;
   term_type                      term_sel_ff, term_sel_in;
   logic signed [COEF_WIDTH-1:0]  coef_ff, coef_in;
   logic [WLEN_WIDTH-1:0]         wlen_ff, wlen_in;
   logic signed [ACC_WIDTH-1:0]   d1_ff, d1_in;
   logic signed [ACC_WIDTH-1:0]   d2_ff, d2_in;
   logic [WLEN_WIDTH-1:0]         count_ff, count_in;
   logic                          sat_ff, sat_in;
   logic [CW-1:0]                 step_ff, step_in;
   logic [ROOT_CNT_W-1:0]         iter_ff, iter_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [ACC_WIDTH-1:0]           mcand_ff, mcand_in;
   logic [MW-1:0]                  mplier_ff, mplier_in;
   logic [TW-1:0]                  term_ff, term_in;
   logic                           neg_ff, neg_in;
   logic [MW-1:0]                  q_ff, q_in;
   logic signed [AW-1:0]           acc_ff, acc_in;
   logic [ROOT_WIDTH-1:0]          rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]          root_ff, root_in;
   logic [ROOT_WIDTH-1:0]          bit_ff, bit_in;
   logic [POWER_WIDTH-1:0]         power_ff, power_in;
   logic                           psat_ff, psat_in;
   logic [POWER_WIDTH-1:0]         rsp_power_ff, rsp_power_in;
   logic [MAG_WIDTH-1:0]           rsp_mag_ff, rsp_mag_in;
   logic                           rsp_ovf_ff, rsp_ovf_in;

   // Combinational helpers
   logic                           cfg_wr;
   logic                           req_acc;
   logic [ACC_WIDTH-1:0]           abs_d1, abs_d2;
   logic [COEF_WIDTH-1:0]          abs_c;
   logic [DIGIT_WIDTH-1:0]         digit;
   logic [ACC_WIDTH+DIGIT_WIDTH-1:0] product;
   logic [TW-1:0]                  mac_term;
   logic signed [PW-1:0]           prod_s, prod_sh;
   logic signed [NW-1:0]           nxt;
   logic                           sat_hi, sat_lo;
   logic signed [ACC_WIDTH-1:0]    d_next;
   logic [WLEN_WIDTH-1:0]          count_inc;
   logic [AW-1:0]                  cross_up;
   logic [AW-1:0]                  add_mag;
   logic                           acc_sub;
   logic signed [AWE-1:0]          acc_x, pw;
   logic                           pw_neg, pw_big;
   logic [POWER_WIDTH-1:0]         power_val;
   logic [ROOT_WIDTH-1:0]          trial;
   logic                           root_ge;
   logic                           emit_go;

   // Handshakes
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_pready = 1'b1;

   // Register readback
   always_comb begin
      case (csr_reg_type'(csr_paddr[2]))
         REG_COEFFICIENT:   csr_prdata = CSR_DATA_WIDTH'($unsigned(coef_ff));
         REG_WINDOW_LENGTH: csr_prdata = CSR_DATA_WIDTH'(wlen_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Magnitudes of the signed operands
   assign abs_d1 = d1_ff[ACC_WIDTH-1] ? ($unsigned(~d1_ff) + ACC_WIDTH'(1)) : $unsigned(d1_ff);
   assign abs_d2 = d2_ff[ACC_WIDTH-1] ? ($unsigned(~d2_ff) + ACC_WIDTH'(1)) : $unsigned(d2_ff);
   assign abs_c  = coef_ff[COEF_WIDTH-1] ? ($unsigned(~coef_ff) + COEF_WIDTH'(1))
                                         : $unsigned(coef_ff);

   // Shared multiplier: one 16-bit digit per cycle, most significant first
   assign digit    = mplier_ff[MW-1 -: DIGIT_WIDTH];
   assign product  = mcand_ff * digit;
   assign mac_term = {term_ff[TW-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}} + TW'(product);

   // Recurrence update: x + floor(c*d1 / 2^14) - d2, then saturate
   assign prod_s  = neg_ff ? -$signed({1'b0, term_ff[ACC_WIDTH+DIGIT_WIDTH-1:0]})
                           :  $signed({1'b0, term_ff[ACC_WIDTH+DIGIT_WIDTH-1:0]});
   assign prod_sh = prod_s >>> COEF_FRAC;
   assign nxt     = NW'(sample_ff) + NW'(prod_sh) - NW'(d2_ff);
   assign sat_hi  = !nxt[NW-1] && (nxt[NW-2:ACC_WIDTH-1] != '0);
   assign sat_lo  =  nxt[NW-1] && (nxt[NW-2:ACC_WIDTH-1] != '1);
   assign d_next  = sat_hi ? $signed({1'b0, {(ACC_WIDTH-1){1'b1}}}) :
                    sat_lo ? $signed({1'b1, {(ACC_WIDTH-1){1'b0}}}) :
                             nxt[ACC_WIDTH-1:0];
   assign count_inc = count_ff + WLEN_WIDTH'(1);

   // Power accumulation: d1^2 + d2^2 - floor(c*d1*d2 / 2^14)
   // A negative cross product rounds its magnitude up before the shift.
   assign cross_up = term_ff[AW-1:0] + AW'((1 << COEF_FRAC) - 1);
   assign add_mag  = (term_sel_ff != TERM_CROSS) ? term_ff[AW-1:0] :
                     neg_ff ? (cross_up >> COEF_FRAC) : (term_ff[AW-1:0] >> COEF_FRAC);
   assign acc_sub  = (term_sel_ff == TERM_CROSS) && !neg_ff;

   // Final shift by 16, clamp at zero, saturate to 63 bits
   assign acc_x     = AWE'(acc_ff);
   assign pw        = acc_x >>> POWER_SHIFT;
   assign pw_neg    = pw[AWE-1];
   assign pw_big    = (pw[AWE-2:POWER_WIDTH] != '0);
   assign power_val = pw_neg ? '0 : (pw_big ? '1 : pw[POWER_WIDTH-1:0]);

   // Square root step
   assign trial   = root_ff + bit_ff;
   assign root_ge = (rem_ff >= trial);

   assign emit_go = !rsp_valid_ff || rsp_tready;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      term_sel_in  = term_sel_ff;
      coef_in      = coef_ff;
      wlen_in      = wlen_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      term_in      = term_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      power_in     = power_ff;
      psat_in      = psat_ff;
      rsp_power_in = rsp_power_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // Configuration writes
      if (cfg_wr) begin
         case (csr_reg_type'(csr_paddr[2]))
            REG_COEFFICIENT:   coef_in = $signed(csr_pwdata[COEF_WIDTH-1:0]);
            REG_WINDOW_LENGTH: wlen_in = csr_pwdata[WLEN_WIDTH-1:0];
            default:           ;
         endcase
      end

      // Output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sample_in   = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
               mcand_in    = abs_d1;
               mplier_in   = MW'(abs_c) << C_SHIFT;
               step_in     = CW'(1);
               term_in     = '0;
               neg_in      = coef_ff[COEF_WIDTH-1] ^ d1_ff[ACC_WIDTH-1];
               term_sel_in = TERM_SAMPLE;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            term_in   = mac_term;
            mplier_in = mplier_ff << DIGIT_WIDTH;
            step_in   = step_ff - CW'(1);
            if (step_ff == CW'(1)) begin
               state_in = (term_sel_ff == TERM_SAMPLE) ? ST_UPDATE : ST_ACCUM;
            end
         end
         ST_UPDATE: begin
            d2_in    = d1_ff;
            d1_in    = d_next;
            sat_in   = sat_ff | sat_hi | sat_lo;
            count_in = count_inc;
            if (count_inc == wlen_ff) begin
               acc_in      = '0;
               term_sel_in = TERM_SQ1;
               state_in    = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            term_in  = '0;
            state_in = ST_MAC;
            case (term_sel_ff)
               TERM_SQ1: begin
                  mcand_in  = abs_d1;
                  mplier_in = MW'(abs_d1) << SQ_SHIFT;
                  step_in   = CW'(ND);
               end
               TERM_SQ2: begin
                  mcand_in  = abs_d2;
                  mplier_in = MW'(abs_d2) << SQ_SHIFT;
                  step_in   = CW'(ND);
               end
               TERM_CQ: begin
                  mcand_in  = abs_d1;
                  mplier_in = MW'(abs_c) << C_SHIFT;
                  step_in   = CW'(1);
               end
               TERM_CROSS: begin
                  mcand_in  = abs_d2;
                  mplier_in = q_ff;
                  step_in   = CW'(NDQ);
                  neg_in    = coef_ff[COEF_WIDTH-1] ^ d1_ff[ACC_WIDTH-1] ^ d2_ff[ACC_WIDTH-1];
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ACCUM: begin
            case (term_sel_ff)
               TERM_SQ1: begin
                  acc_in      = acc_ff + $signed(add_mag);
                  term_sel_in = TERM_SQ2;
                  state_in    = ST_LOAD;
               end
               TERM_SQ2: begin
                  acc_in      = acc_ff + $signed(add_mag);
                  term_sel_in = TERM_CQ;
                  state_in    = ST_LOAD;
               end
               TERM_CQ: begin
                  q_in        = term_ff[MW-1:0];
                  term_sel_in = TERM_CROSS;
                  state_in    = ST_LOAD;
               end
               TERM_CROSS: begin
                  acc_in   = acc_sub ? (acc_ff - $signed(add_mag)) : (acc_ff + $signed(add_mag));
                  state_in = ST_POWER;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_POWER: begin
            power_in = power_val;
            psat_in  = !pw_neg && pw_big;
            rem_in   = ROOT_WIDTH'(power_val);
            root_in  = '0;
            bit_in   = ROOT_BIT_INIT;
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_ge) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + ROOT_CNT_W'(1);
            if (iter_ff == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = power_ff;
               rsp_mag_in   = root_ff[MAG_WIDTH-1:0];
               rsp_ovf_in   = sat_ff | psat_ff;
               d1_in        = '0;
               d2_in        = '0;
               count_in     = '0;
               sat_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_sel_ff  <= TERM_SAMPLE;
         coef_ff      <= '0;
         wlen_ff      <= WLEN_WIDTH'(1024);
         d1_ff        <= '0;
         d2_ff        <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         step_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_sel_ff  <= term_sel_in;
         coef_ff      <= coef_in;
         wlen_ff      <= wlen_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      term_ff      <= term_in;
      neg_ff       <= neg_in;
      q_ff         <= q_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      power_ff     <= power_in;
      psat_ff      <= psat_in;
      rsp_power_ff <= rsp_power_in;
      rsp_mag_ff   <= rsp_mag_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_mag_ff, rsp_power_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> sv/gtp_checker.sv
// Port-level checker for the Goertzel tone power block, bound to the top level.
`default_nettype none

module gtp_checker import gtp_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic                      rsp_tuser
);

   logic [POWER_WIDTH-1:0] chk_power;
   logic [MAG_WIDTH-1:0]   chk_mag;
   logic [65:0]            mag_sq;
   logic [65:0]            next_sq;

   assign chk_power = rsp_tdata[POWER_WIDTH-1:0];
   assign chk_mag   = rsp_tdata[POWER_WIDTH+MAG_WIDTH-1:POWER_WIDTH];
   assign mag_sq    = 66'(chk_mag) * 66'(chk_mag);
   assign next_sq   = (66'(chk_mag) + 66'(1)) * (66'(chk_mag) + 66'(1));

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result transaction changed while stalled");

   // Magnitude is the floor square root of power
   a_mag_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mag_sq <= 66'(chk_power)) && (next_sq > 66'(chk_power)))
      else $error("magnitude is not the floor square root of power");

   // An accepted sample keeps the block busy, so req_tready drops after each accept
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted on consecutive cycles");

   // Padding bit of the result stays clear
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_WIDTH-1])
      else $error("result padding bit set");

endmodule

bind goertzel_tone_power gtp_checker u_gtp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> sim/tb_goertzel_tone_power.sv
// Self-checking testbench for the single-bin Goertzel tone power detector.
module tb_goertzel_tone_power;
   import gtp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Wide signed type: holds every product of the power term exactly
   typedef logic signed [191:0] wide_type;

   typedef struct {
      logic [POWER_WIDTH-1:0] power;
      logic [MAG_WIDTH-1:0]   magnitude;
      logic                   overflow;
   } tone_result_type;

   localparam int       SAMPLE_BITS     = SAMPLE_WIDTH_DEF;
   localparam int       ACC_BITS        = ACC_WIDTH_DEF;
   localparam int       POWER_DROP      = 16;
   localparam int       MAX_IDLE        = 14;
   localparam int       HOLD_OFF_CYCLES = 400;
   localparam int       SETTLE_CYCLES   = 100;
   localparam int       RANDOM_ITEMS    = 220;
   localparam int       LIMIT_CYCLES    = 250_000;
   localparam wide_type ACC_MAX   = (wide_type'(1) <<< (ACC_BITS - 1)) - wide_type'(1);
   localparam wide_type ACC_MIN   = -ACC_MAX - wide_type'(1);
   localparam wide_type POWER_MAX = (wide_type'(1) <<< POWER_WIDTH) - wide_type'(1);
   localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [15:0] SAMPLE_MIN = 16'h8000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata = '0;   // [15:0] sample
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]            rsp_tdata;        // [62:0] power, [94:63] magnitude
   logic                                 rsp_tuser;        // [0] overflow
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]            csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]            csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]            csr_prdata;
   logic                                 csr_pready;

   // Stimulus and scoreboard
   logic [15:0]     sample_queue[$];
   tone_result_type pending_powers[$];
   int              req_issued = 0;
   int              req_taken = 0;
   int              rsp_taken = 0;
   int              rsp_seen = 0;
   int              send_gap = 0;
   int              take_hold = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   bit              send_gaps_on = 1'b0;
   bit              take_gaps_on = 1'b0;
   bit              hold_off_request = 1'b0;
   bit              hold_off_done = 1'b0;

   // Predictor state and shadow registers
   logic signed [ACC_BITS-1:0]   tone_d1 = '0;
   logic signed [ACC_BITS-1:0]   tone_d2 = '0;
   logic [15:0]                  tone_count = '0;
   bit                           tone_sat = 1'b0;
   logic signed [COEF_WIDTH-1:0] model_coef = '0;
   logic [WLEN_WIDTH-1:0]        model_wlen = 16'd1024;

   goertzel_tone_power DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_goertzel_tone_power NOT OK");
         $finish;
      end
   end

   // Floor square root, two bits per step
   function automatic logic [MAG_WIDTH-1:0] floor_root(input logic [63:0] value);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = value;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[MAG_WIDTH-1:0];
   endfunction

   // One sample through the recurrence; queues the tone power at window end
   task automatic goertzel_step(input logic signed [SAMPLE_BITS-1:0] x);
      wide_type        coef_w;
      wide_type        s1;
      wide_type        s2;
      wide_type        acc;
      wide_type        pw;
      tone_result_type res;
      coef_w = model_coef;
      s1     = tone_d1;
      s2     = tone_d2;
      acc    = wide_type'(x) + ((coef_w * s1) >>> COEF_FRAC) - s2;
      if (acc > ACC_MAX) begin
         acc = ACC_MAX;
         tone_sat = 1'b1;
      end else if (acc < ACC_MIN) begin
         acc = ACC_MIN;
         tone_sat = 1'b1;
      end
      tone_d2    = tone_d1;
      tone_d1    = acc[ACC_BITS-1:0];
      tone_count = tone_count + 16'd1;
      if (tone_count == model_wlen) begin
         s1 = tone_d1;
         s2 = tone_d2;
         pw = s1 * s1 + s2 * s2 - (((coef_w * s1) * s2) >>> COEF_FRAC);
         pw = pw >>> POWER_DROP;
         res.overflow = tone_sat;
         if (pw < 0) begin
            res.power = '0;
         end else if (pw > POWER_MAX) begin
            res.power    = POWER_MAX[POWER_WIDTH-1:0];
            res.overflow = 1'b1;
         end else begin
            res.power = pw[POWER_WIDTH-1:0];
         end
         res.magnitude = floor_root({1'b0, res.power});
         pending_powers.push_back(res);
         tone_d1    = '0;
         tone_d2    = '0;
         tone_count = '0;
         tone_sat   = 1'b0;
      end
   endtask

   // Monitor: check results, then predict from accepted samples
   always @(posedge clock) begin : monitor
      tone_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken <= rsp_taken + 1;
            if (pending_powers.size() == 0) begin
               $error("unexpected result transaction: power %0d", rsp_tdata[62:0]);
               mismatches = mismatches + 1;
            end else begin
               want = pending_powers.pop_front();
               if (rsp_tdata[62:0] !== want.power) begin
                  $error("power: expected %0d, actual %0d", want.power, rsp_tdata[62:0]);
                  mismatches = mismatches + 1;
               end
               if (rsp_tdata[94:63] !== want.magnitude) begin
                  $error("magnitude: expected %0d, actual %0d",
                         want.magnitude, rsp_tdata[94:63]);
                  mismatches = mismatches + 1;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %0d, actual %0d", want.overflow, rsp_tuser);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken <= req_taken + 1;
            goertzel_step(req_tdata[SAMPLE_BITS-1:0]);
         end
      end
   end

   // Sample driver: one transaction per queued sample, random gaps between when enabled
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_taken != req_issued) begin
         // still waiting for the handshake
      end else if (send_gap != 0) begin
         req_tvalid <= 1'b0;
         send_gap   <= send_gap - 1;
      end else if (sample_queue.size() != 0) begin
         req_tdata  <= sample_queue.pop_front();
         req_tvalid <= 1'b1;
         req_issued <= req_issued + 1;
         send_gap   <= send_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result receiver: random stall after each result when enabled, one long hold-off on request
   always @(negedge clock) begin : receiver
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_request && !hold_off_done) begin
         rsp_tready    <= 1'b0;
         take_hold     <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else if (take_hold != 0) begin
         rsp_tready <= 1'b0;
         take_hold  <= take_hold - 1;
      end else if (rsp_taken != rsp_seen) begin
         rsp_seen <= rsp_taken;
         stall = take_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            take_hold  <= stall - 1;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         default: return 16'($urandom);
      endcase
   endfunction

   // Wait until every sample is taken and every result checked, then let the block go idle
   task automatic settle();
      while (sample_queue.size() != 0 || req_issued != req_taken || pending_powers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic csr_access(input csr_reg_type idx, input logic [15:0] value);
      logic [CSR_DATA_WIDTH-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[15:0] !== value) begin
         $error("%s readback: expected %0h, actual %0h", idx.name(), value, readback[15:0]);
         mismatches = mismatches + 1;
      end
      if (idx == REG_COEFFICIENT)
         model_coef = value;
      else
         model_wlen = value;
   endtask

   task automatic configure(input logic [15:0] coef, input logic [15:0] wlen);
      settle();
      csr_access(REG_COEFFICIENT, coef);
      csr_access(REG_WINDOW_LENGTH, wlen);
   endtask

   // Stimulus
   initial begin : stimulus
      int items;
      int n;
      int wlen;
      logic [15:0] coef;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: coefficient 0, window of 1024
      for (int k = 0; k < 1024; k++) sample_queue.push_back(random_sample());

      // Directed: sample extremes and alternating bit patterns, one result each
      configure(16'h0000, 16'd1);
      sample_queue = '{SAMPLE_MAX, SAMPLE_MIN, 16'h0000, 16'hFFFF, 16'h0001,
                       16'h5555, 16'hAAAA};
      // Coefficient extremes with full-scale input, then a mid coefficient with random input
      configure(16'h7FFF, 16'd4);
      repeat (4) sample_queue.push_back(SAMPLE_MAX);
      configure(16'h8000, 16'd3);
      sample_queue.push_back(SAMPLE_MIN);
      sample_queue.push_back(SAMPLE_MAX);
      sample_queue.push_back(SAMPLE_MIN);
      configure(16'h4000, 16'd5);
      repeat (5) sample_queue.push_back(random_sample());
      configure(16'h7FFF, 16'd2);
      repeat (2) sample_queue.push_back(SAMPLE_MAX);

      // Back-pressure: one result per sample while the receiver holds off
      configure(16'($urandom), 16'd1);
      hold_off_request = 1'b1;
      repeat (40) sample_queue.push_back(random_sample());

      // Random phases: new settings, gaps on or off per side
      items = 0;
      while (items < RANDOM_ITEMS) begin
         settle();
         send_gaps_on = ($urandom_range(0, 3) != 0);
         take_gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 4))
            0:       coef = 16'h7FFF;
            1:       coef = 16'h8000;
            default: coef = 16'($urandom);
         endcase
         wlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
         // keep the window ahead of a partly filled count
         if (wlen <= tone_count) wlen = wlen + tone_count;
         configure(coef, 16'(wlen));
         n = wlen * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, wlen) - 1;
         for (int k = 0; k < n; k++) sample_queue.push_back(random_sample());
         items = items + n;
      end

      settle();
      if (mismatches == 0)
         $display("tb_goertzel_tone_power OK");
      else
         $display("tb_goertzel_tone_power NOT OK");
      $finish;
   end

endmodule
